/* hw/rtl/hankel_mac_signed_rows_macros.svh */
// assertion macros used by the checker of this block
// every macro expects clk and arst_n in scope
`ifndef HANKEL_MAC_SIGNED_ROWS_MACROS_SVH
`define HANKEL_MAC_SIGNED_ROWS_MACROS_SVH

// same-cycle implication, off during reset
`define HMSR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off during reset
`define HMSR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/hmsr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmsr_pkg
// word types, op codes and controller/datapath interface structs
// ----------------------------------------------------------------------------
package hmsr_pkg;

	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_MAC  = 2'd1,
		OP_EMIT = 2'd2,
		OP_NONE = 2'd3
	} hmsr_op_t;

	typedef struct packed {
		logic [1:0]         op;
		logic [6:0]         factor_index;
		logic [6:0]         step;
		logic [2:0]         column;
		logic signed [31:0] data_value;
		logic               negate_even;
	} hmsr_in_t;

	typedef struct packed {
		logic signed [31:0] out_value;
		logic [1:0]         out_row;
		logic [2:0]         out_column;
		logic               last;
		logic               clipped;
	} hmsr_out_t;

	// controller to datapath
	typedef struct packed {
		logic cap;       // capture the accepted word
		logic fwr;       // factor load
		logic mac_rd;    // read factor and accumulator for current row
		logic mac_mul;   // register product
		logic mac_add;   // saturating add and write back
		logic emit_rd;   // read accumulator k
		logic emit_neg;  // optional negation stage
		logic emit_out;  // round, clip, load result register, clear entry
		logic last;      // final entry of an emit
	} hmsr_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic row_skip;  // factor index step+row beyond the table
		logic out_free;  // result register can take a word
	} hmsr_sts_t;

endpackage

/* hw/rtl/hmsr_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmsr_ctrl
// sequencer for factor loads, per-row multiply-adds and the emit walk
// ----------------------------------------------------------------------------
module hmsr_ctrl #(
	parameter int ROWS = 4,
	parameter int COLS = 8,
	localparam int RW  = $clog2(ROWS),
	localparam int CW  = (COLS > 1) ? $clog2(COLS) : 1,
	localparam int NE  = ROWS * COLS,
	localparam int KW  = $clog2(NE)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	input  logic [1:0]          item_op,
	input  logic [2:0]          item_column,
	output logic                item_stall,
	input  hmsr_pkg::hmsr_sts_t sts,
	output hmsr_pkg::hmsr_cmd_t cmd,
	output logic [RW-1:0]       row,
	output logic [CW-1:0]       col,
	output logic [KW-1:0]       k
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_M_RD,
		ST_M_MUL,
		ST_M_ADD,
		ST_E_RD,
		ST_E_NEG,
		ST_E_OUT
	} state_t;

	state_t        state_q;
	logic [RW-1:0] row_q;
	logic [CW-1:0] col_q;
	logic [KW-1:0] k_q;
	logic          accept;
	logic          row_last;
	logic          col_last;
	logic          k_last;

	assign item_stall = (state_q != ST_IDLE);
	assign accept     = item_valid && !item_stall;
	assign row_last   = (32'(row_q) == ROWS - 1);
	assign col_last   = (32'(col_q) == COLS - 1);
	assign k_last     = (32'(k_q) == NE - 1);
	assign row        = row_q;
	assign col        = col_q;
	assign k          = k_q;

	always_comb begin
		cmd          = '0;
		cmd.cap      = accept;
		cmd.fwr      = accept && (item_op == hmsr_pkg::OP_LOAD);
		cmd.mac_rd   = (state_q == ST_M_RD) && !sts.row_skip;
		cmd.mac_mul  = (state_q == ST_M_MUL);
		cmd.mac_add  = (state_q == ST_M_ADD);
		cmd.emit_rd  = (state_q == ST_E_RD);
		cmd.emit_neg = (state_q == ST_E_NEG);
		cmd.emit_out = (state_q == ST_E_OUT) && sts.out_free;
		cmd.last     = k_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_q   <= '0;
			col_q   <= '0;
			k_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					row_q <= '0;
					col_q <= '0;
					k_q   <= '0;
					if (accept && (item_op == hmsr_pkg::OP_MAC) && (32'(item_column) < COLS))
						state_q <= ST_M_RD;
					else if (accept && (item_op == hmsr_pkg::OP_EMIT))
						state_q <= ST_E_RD;
				end
				ST_M_RD: begin
					// rows whose factor lies past the table add nothing
					if (sts.row_skip) begin
						if (row_last)
							state_q <= ST_IDLE;
						else
							row_q <= row_q + 1'b1;
					end else begin
						state_q <= ST_M_MUL;
					end
				end
				ST_M_MUL: state_q <= ST_M_ADD;
				ST_M_ADD: begin
					if (row_last) begin
						state_q <= ST_IDLE;
					end else begin
						row_q   <= row_q + 1'b1;
						state_q <= ST_M_RD;
					end
				end
				ST_E_RD:  state_q <= ST_E_NEG;
				ST_E_NEG: state_q <= ST_E_OUT;
				ST_E_OUT: begin
					if (sts.out_free) begin
						if (k_last) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_E_RD;
							k_q     <= k_q + 1'b1;
							if (col_last) begin
								col_q <= '0;
								row_q <= row_q + 1'b1;
							end else begin
								col_q <= col_q + 1'b1;
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* hw/rtl/hmsr_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmsr_dp
// factor table, accumulator memory, shared multiplier and result register
// ----------------------------------------------------------------------------
module hmsr_dp #(
	parameter int ROWS         = 4,
	parameter int COLS         = 8,
	parameter int FACTOR_DEPTH = 128,
	localparam int RW  = $clog2(ROWS),
	localparam int CW  = (COLS > 1) ? $clog2(COLS) : 1,
	localparam int NE  = ROWS * COLS,
	localparam int KW  = $clog2(NE),
	localparam int FIW = $clog2(FACTOR_DEPTH),
	localparam int SW  = ((FIW > 7) ? FIW : 7) + 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  hmsr_pkg::hmsr_in_t   item,
	input  hmsr_pkg::hmsr_cmd_t  cmd,
	input  logic [RW-1:0]        row,
	input  logic [CW-1:0]        col,
	input  logic [KW-1:0]        k,
	output hmsr_pkg::hmsr_sts_t  sts,
	output logic                 result_valid,
	input  logic                 result_stall,
	output hmsr_pkg::hmsr_out_t  result
);

	localparam logic signed [63:0] ACC_MAX = {1'b0, {63{1'b1}}};
	localparam logic signed [63:0] ACC_MIN = {1'b1, {63{1'b0}}};
	localparam logic signed [48:0] RND_MAX = 49'sd2147483647;
	localparam logic signed [48:0] RND_MIN = -49'sd2147483648;

	logic signed [31:0] fmem [FACTOR_DEPTH];
	logic        [63:0] amem [NE];
	logic [NE-1:0]      valid_q;
	logic [NE-1:0]      sat_q;

	logic [6:0]         step_q;
	logic [2:0]         col_in_q;
	logic signed [31:0] data_q;
	logic               neg_even_q;

	logic [SW-1:0]      fidx;
	logic [KW-1:0]      mac_addr;
	logic [KW-1:0]      rd_addr;
	logic signed [31:0] f_rd_q;
	logic signed [63:0] a_rd_q;
	logic               av_rd_q;
	logic               as_rd_q;

	logic signed [63:0] prod_c;
	logic signed [63:0] prod_s1;
	logic signed [63:0] base;
	logic signed [63:0] sum;
	logic               ovf_pos;
	logic               ovf_neg;
	logic signed [63:0] add_res;

	logic               neg_sel;
	logic signed [63:0] neg_s1;
	logic               nsat_s1;
	logic signed [48:0] rnd;
	logic signed [31:0] rnd_clip;
	logic               rnd_sat;

	logic               res_valid_q;
	hmsr_pkg::hmsr_out_t res_q;

	assign fidx         = SW'(step_q) + SW'(row);
	assign mac_addr     = KW'(32'(row) * COLS + 32'(col_in_q));
	assign rd_addr      = cmd.mac_rd ? mac_addr : k;
	assign sts.row_skip = (fidx >= SW'(FACTOR_DEPTH));
	assign sts.out_free = !res_valid_q || !result_stall;

	// captured word
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			step_q     <= item.step;
			col_in_q   <= item.column;
			data_q     <= item.data_value;
			neg_even_q <= item.negate_even;
		end
	end

	// factor table, undefined until written
	always_ff @(posedge clk) begin
		if (cmd.fwr && (32'(item.factor_index) < FACTOR_DEPTH))
			fmem[FIW'(item.factor_index)] <= item.data_value;
		if (cmd.mac_rd)
			f_rd_q <= fmem[fidx[FIW-1:0]];
	end

	// accumulator memory, one read and one write port
	always_ff @(posedge clk) begin
		if (cmd.mac_rd || cmd.emit_rd) begin
			a_rd_q  <= amem[rd_addr];
			av_rd_q <= valid_q[rd_addr];
			as_rd_q <= sat_q[rd_addr];
		end
		if (cmd.mac_add)
			amem[mac_addr] <= add_res;
	end

	// entry valid and saturation flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			sat_q   <= '0;
		end else if (cmd.mac_add) begin
			valid_q[mac_addr] <= 1'b1;
			if (ovf_pos || ovf_neg)
				sat_q[mac_addr] <= 1'b1;
		end else if (cmd.emit_out) begin
			valid_q[k] <= 1'b0;
			sat_q[k]   <= 1'b0;
		end
	end

	// multiply stage
	assign prod_c = f_rd_q * data_q;
	always_ff @(posedge clk) begin
		if (cmd.mac_mul)
			prod_s1 <= prod_c;
	end

	// saturating accumulate
	assign base    = av_rd_q ? a_rd_q : 64'sd0;
	assign sum     = base + prod_s1;
	assign ovf_pos = !base[63] && !prod_s1[63] && sum[63];
	assign ovf_neg = base[63] && prod_s1[63] && !sum[63];
	assign add_res = ovf_pos ? ACC_MAX : (ovf_neg ? ACC_MIN : sum);

	// negation stage, row parity picks the rows
	assign neg_sel = row[0] ^ neg_even_q;
	always_ff @(posedge clk) begin
		if (cmd.emit_neg) begin
			if (neg_sel && (base == ACC_MIN)) begin
				neg_s1  <= ACC_MAX;
				nsat_s1 <= 1'b1;
			end else begin
				neg_s1  <= neg_sel ? -base : base;
				nsat_s1 <= as_rd_q;
			end
		end
	end

	// round to nearest, ties up, then clip to 32 bits
	assign rnd      = {neg_s1[63], neg_s1[63:16]} + {48'd0, neg_s1[15]};
	assign rnd_sat  = (rnd > RND_MAX) || (rnd < RND_MIN);
	assign rnd_clip = (rnd > RND_MAX) ? 32'sh7FFF_FFFF :
	                  ((rnd < RND_MIN) ? 32'sh8000_0000 : rnd[31:0]);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (cmd.emit_out)
			res_valid_q <= 1'b1;
		else if (!result_stall)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_out) begin
			res_q.out_value  <= rnd_clip;
			res_q.out_row    <= 2'(row);
			res_q.out_column <= 3'(col);
			res_q.last       <= cmd.last;
			res_q.clipped    <= nsat_s1 || rnd_sat;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

/* hw/rtl/hankel_mac_signed_rows.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hankel_mac_signed_rows
// hankel-indexed multiply-accumulate over a row x column accumulator grid
// ----------------------------------------------------------------------------
// usage
//   item channel (item_valid / item_stall / item) takes one word per accept:
//     op load  writes data_value to factor slot factor_index, no stall
//     op mac   adds factor[step+r] * data_value into accumulator (r, column)
//              for every row r: read, multiply and saturating add through
//              the one multiplier; a row whose factor lies past the table is
//              skipped and adds nothing
//     op emit  walks all ROWS*COLS accumulators in row-major order, each
//              through memory read, negate and round/clip steps, and clears
//              each entry as its result is loaded
//   result channel (result_valid / result_stall / result) comes from an
//   output register; the next item is taken while the last result waits
//   item_stall is high while a sample or an emit is in progress
//   a stalled result holds the walk in its round/clip step, nothing is lost
//   reset clears saturation flags, and accumulators through per-entry valid
//   bits, at once; the factor table is not cleared and must be loaded first
// ----------------------------------------------------------------------------
module hankel_mac_signed_rows #(
	parameter int ROWS         = 4,
	parameter int COLS         = 8,
	parameter int FACTOR_DEPTH = 128
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  hmsr_pkg::hmsr_in_t  item,
	output logic                result_valid,
	input  logic                result_stall,
	output hmsr_pkg::hmsr_out_t result
);

	localparam int RW = $clog2(ROWS);
	localparam int CW = (COLS > 1) ? $clog2(COLS) : 1;
	localparam int KW = $clog2(ROWS * COLS);

	// command and status between sequencer and datapath
	hmsr_pkg::hmsr_cmd_t cmd;
	hmsr_pkg::hmsr_sts_t sts;

	// walk position: row, column and flat entry index
	logic [RW-1:0] row;
	logic [CW-1:0] col;
	logic [KW-1:0] k;

	hmsr_ctrl #(
		.ROWS (ROWS),
		.COLS (COLS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_op     (item.op),
		.item_column (item.column),
		.item_stall  (item_stall),
		.sts         (sts),
		.cmd         (cmd),
		.row         (row),
		.col         (col),
		.k           (k)
	);

	hmsr_dp #(
		.ROWS         (ROWS),
		.COLS         (COLS),
		.FACTOR_DEPTH (FACTOR_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.row          (row),
		.col          (col),
		.k            (k),
		.sts          (sts),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

/* hw/rtl/hankel_mac_signed_rows_chk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hankel_mac_signed_rows_chk
// port-level checks on sequencing of items and result words
// ----------------------------------------------------------------------------
`include "hankel_mac_signed_rows_macros.svh"

module hankel_mac_signed_rows_chk (
	input logic                clk,
	input logic                arst_n,
	input logic                item_valid,
	input logic                item_stall,
	input hmsr_pkg::hmsr_in_t  item,
	input logic                result_valid,
	input logic                result_stall,
	input hmsr_pkg::hmsr_out_t result
);

	logic item_acc;
	logic item_emit;
	logic item_load;
	logic res_acc;
	logic res_wait;
	logic res_last;

	assign item_acc  = item_valid && !item_stall;
	assign item_emit = item_acc && (item.op == hmsr_pkg::OP_EMIT);
	assign item_load = item_acc && (item.op == hmsr_pkg::OP_LOAD);
	assign res_acc   = result_valid && !result_stall;
	assign res_wait  = result_valid && result_stall;
	assign res_last  = result_valid && result.last;

	// stalled result word holds
	`HMSR_ASSERT_NEXT(a_res_hold, res_wait, result_valid && $stable(result), "result moved under stall")

	// an emit blocks further items while it walks
	`HMSR_ASSERT_NEXT(a_emit_busy, item_emit, item_stall, "item taken during emit")

	// a factor load leaves the item channel free for the next word
	`HMSR_ASSERT_NEXT(a_load_fast, item_load, !item_stall, "factor load did not return to idle")

	// the word after a last word is never another last
	`HMSR_ASSERT_NEXT(a_last_once, res_acc && res_last, !res_last, "two last words in a row")

endmodule

bind hankel_mac_signed_rows hankel_mac_signed_rows_chk u_chk (.*);
